// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define RHH_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle
`define RHH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rhh_pkg.sv -----
`default_nettype none
package rhh_pkg;

  localparam int REG_W  = 40;
  localparam int AP_W   = 13;
  localparam int ROW_W  = 12;
  localparam int OUT_W  = 48;
  localparam int FRAC_W = 16;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [1:0] REG_KIN = 2'd0;
  localparam logic [1:0] REG_NUC = 2'd1;
  localparam logic [1:0] REG_INV = 2'd2;
  localparam logic [1:0] REG_AP  = 2'd3;

  localparam logic [REG_W-1:0] KIN_RST = 40'd5349877547;
  localparam logic [REG_W-1:0] NUC_RST = 40'd37449143;
  localparam logic [REG_W-1:0] INV_RST = 40'd18724571;
  localparam logic [AP_W-1:0]  AP_RST  = 13'd4000;

  localparam logic [OUT_W-1:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;

endpackage
`default_nettype wire

// ----- sv/radial_hartree_hamiltonian_diagonal.sv -----
`default_nettype none
// Channel  | Ports                                       | Beat
// input    | in_valid/in_stall, action, sample, row      | one command
// result   | out_valid/out_stall, row_index, diag, off,  | one row, reads only
//          | status                                      |
// config   | psel/penable/pwrite/paddr/pwdata/prdata     | 64-bit regs at 8*i
//
// Load leaves the block idle. Finish walks the grid on the shared iterative divider, one
// quotient bit per cycle. A valid read makes two divider passes and a serial multiply;
// an error read goes straight to the result.
// Reset is synchronous on rst_n; the prefix and tail memories are not cleared.
// A result waiting under out_stall holds only a later read; loads and finishes go on.
module radial_hartree_hamiltonian_diagonal #(
  parameter int MAX_POINTS  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_action,
  input  wire logic signed [SAMPLE_BITS-1:0]    in_sample,
  input  wire logic [rhh_pkg::ROW_W-1:0]        in_row,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [rhh_pkg::ROW_W-1:0]             out_row_index,
  output logic signed [rhh_pkg::OUT_W-1:0]      out_diag_value,
  output logic signed [rhh_pkg::OUT_W-1:0]      out_off_diag_value,
  output logic [1:0]                            out_status,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [4:0]                       paddr,
  input  wire logic [63:0]                      pwdata,
  output logic [63:0]                           prdata,
  output logic                                  pready
);

  localparam int REG_W = rhh_pkg::REG_W;
  localparam int OUT_W = rhh_pkg::OUT_W;
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int PW    = 2 * SAMPLE_BITS - 1 + AW;
  localparam int TW    = PW + 17;
  localparam int DVW   = (TW > REG_W) ? TW : REG_W;
  localparam int DSW0  = (PW > 2 * AW) ? PW : 2 * AW;
  localparam int DSW   = (DSW0 > rhh_pkg::AP_W) ? DSW0 : rhh_pkg::AP_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FIN_CHK, S_FIN_PRD, S_FIN_DIV, S_FIN_NORM,
    S_RD_TAIL, S_RD_DIV1, S_RD_MUL, S_RD_DIV2, S_RD_SUM, S_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [REG_W-1:0]          kin_r, nuc_r, inv_r;
  logic [rhh_pkg::AP_W-1:0]  ap_r;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kin_r <= rhh_pkg::KIN_RST;
      nuc_r <= rhh_pkg::NUC_RST;
      inv_r <= rhh_pkg::INV_RST;
      ap_r  <= rhh_pkg::AP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        rhh_pkg::REG_KIN: kin_r <= pwdata[REG_W-1:0];
        rhh_pkg::REG_NUC: nuc_r <= pwdata[REG_W-1:0];
        rhh_pkg::REG_INV: inv_r <= pwdata[REG_W-1:0];
        rhh_pkg::REG_AP:  ap_r  <= pwdata[rhh_pkg::AP_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      rhh_pkg::REG_KIN: prdata = 64'(kin_r);
      rhh_pkg::REG_NUC: prdata = 64'(nuc_r);
      rhh_pkg::REG_INV: prdata = 64'(inv_r);
      rhh_pkg::REG_AP:  prdata = 64'(ap_r);
    endcase
  end

  // memories
  logic [PW-1:0] prefix_mem [MAX_POINTS];
  logic [TW-1:0] tail_mem   [MAX_POINTS];
  logic [PW-1:0] prefix_rd_r;
  logic [TW-1:0] tail_rd_r;

  logic          pw_en, pr_en, tw_en, tr_en;
  logic [AW-1:0] pw_addr, pr_addr, tw_addr, tr_addr;
  logic [PW-1:0] pw_data;
  logic [TW-1:0] tw_data;

  always_ff @(posedge clk) begin
    if (pw_en) prefix_mem[pw_addr] <= pw_data;
    if (pr_en) prefix_rd_r <= prefix_mem[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (tw_en) tail_mem[tw_addr] <= tw_data;
    if (tr_en) tail_rd_r <= tail_mem[tr_addr];
  end

  // block state
  logic [CW-1:0]    load_cnt_r;
  logic [PW-1:0]    run_r;
  logic             ready_r;
  logic [PW-1:0]    norm_r;
  logic [CW-1:0]    fin_pts_r;
  logic [AW-1:0]    j_r;
  logic [AW-1:0]    nm1_r;
  logic [TW-1:0]    acc_r;
  logic [2*AW-1:0]  jsq_r;
  logic             use_mem_r;
  logic [rhh_pkg::ROW_W-1:0] row_r;
  logic [OUT_W-2:0] inter_r;
  logic [REG_W-1:0] nucq_r;

  logic [rhh_pkg::ROW_W-1:0] res_row_r;
  logic [OUT_W-1:0]          res_diag_r, res_off_r;
  logic [1:0]                res_status_r;

  logic                      out_valid_r;
  logic [rhh_pkg::ROW_W-1:0] out_row_r;
  logic [OUT_W-1:0]          out_diag_r, out_off_r;
  logic [1:0]                out_status_r;

  // input side
  logic                       accept;
  logic [SAMPLE_BITS-1:0]     mag;
  logic [2*SAMPLE_BITS-1:0]   sq;
  logic [CW-1:0]              cnt_eff;
  logic [PW-1:0]              sum_base, run_nxt;
  logic                       load_ok;
  logic [CW-1:0]              n_calc;
  logic                       row_bad;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid & ~in_stall;

  assign mag      = in_sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - $unsigned(in_sample))
                                              : $unsigned(in_sample);
  assign sq       = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
  assign cnt_eff  = ready_r ? CW'(0) : load_cnt_r;
  assign sum_base = ready_r ? PW'(0) : run_r;
  assign run_nxt  = sum_base + PW'(sq);
  assign load_ok  = (cnt_eff != CW'(MAX_POINTS));
  assign n_calc   = (32'(ap_r) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(ap_r);
  assign row_bad  = !ready_r || (32'(in_row) >= 32'(fin_pts_r));

  // finish walk helpers
  logic [AW-1:0] idx;
  logic          idx_lt, nm1_lt;
  logic [PW-1:0] p_sel;
  logic [TW-1:0] acc_sum;

  assign idx     = j_r - AW'(1);
  assign idx_lt  = CW'(idx) < load_cnt_r;
  assign nm1_lt  = CW'(nm1_r) < load_cnt_r;
  assign p_sel   = use_mem_r ? prefix_rd_r : run_r;

  // divider, shared by finish and read, and multiplier
  logic            div_start, div_done;
  logic [DVW-1:0]  div_num, div_q;
  logic [DSW-1:0]  div_den;
  logic            mul_start, mul_done;
  logic [OUT_W-2:0] mul_prod;

  assign acc_sum = acc_r + TW'(div_q);

  assign div_start = (state_r == S_FIN_PRD) || (state_r == S_RD_TAIL) ||
                     ((state_r == S_RD_MUL) && mul_done);
  assign mul_start = (state_r == S_RD_DIV1) && div_done;

  always_comb begin
    priority if (state_r == S_FIN_PRD) begin
      div_num = DVW'({p_sel, {rhh_pkg::FRAC_W{1'b0}}});
      div_den = DSW'(jsq_r);
    end else if (state_r == S_RD_TAIL) begin
      div_num = DVW'(tail_rd_r);
      div_den = DSW'(norm_r);
    end else begin
      div_num = DVW'(nuc_r);
      div_den = DSW'(rhh_pkg::AP_W'(row_r) + rhh_pkg::AP_W'(1));
    end
  end

  rhh_div #(.NW(DVW), .DW(DSW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  rhh_mul #(.AW(TW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (TW'(div_q)),
    .b     (inv_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // memory ports
  assign pw_en   = accept && (in_action == rhh_pkg::ACT_LOAD) && load_ok;
  assign pw_addr = cnt_eff[AW-1:0];
  assign pw_data = run_nxt;

  assign pr_en   = (state_r == S_FIN_CHK);
  assign pr_addr = (j_r == '0) ? nm1_r : idx;

  assign tw_en   = ((state_r == S_FIN_CHK) && (j_r == '0)) ||
                   ((state_r == S_FIN_DIV) && div_done);
  assign tw_addr = j_r;
  assign tw_data = (state_r == S_FIN_CHK) ? acc_r : acc_sum;

  assign tr_en   = accept && (in_action == rhh_pkg::ACT_READ);
  assign tr_addr = AW'(in_row);

  // diagonal sum, saturated at the upper end of the output range
  logic signed [OUT_W+1:0] diag_full;
  logic [OUT_W-1:0]        diag_sat;

  assign diag_full = $signed((OUT_W+2)'(kin_r)) - $signed((OUT_W+2)'(nucq_r))
                   + $signed((OUT_W+2)'(inter_r));
  assign diag_sat  = (diag_full > $signed((OUT_W+2)'(rhh_pkg::OUT_MAX))) ? rhh_pkg::OUT_MAX
                   : diag_full[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_cnt_r  <= '0;
      run_r       <= '0;
      ready_r     <= 1'b0;
      norm_r      <= '0;
      fin_pts_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_EMIT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_action)
              rhh_pkg::ACT_LOAD: begin
                ready_r    <= 1'b0;
                load_cnt_r <= load_ok ? cnt_eff + CW'(1) : cnt_eff;
                run_r      <= load_ok ? run_nxt : sum_base;
              end
              rhh_pkg::ACT_FINISH: begin
                if (n_calc == '0) begin
                  norm_r    <= '0;
                  fin_pts_r <= '0;
                  ready_r   <= 1'b1;
                end else begin
                  nm1_r   <= AW'(n_calc - CW'(1));
                  j_r     <= AW'(n_calc - CW'(1));
                  acc_r   <= '0;
                  state_r <= S_FIN_CHK;
                end
              end
              rhh_pkg::ACT_READ: begin
                row_r     <= in_row;
                res_row_r <= in_row;
                res_diag_r <= '0;
                res_off_r  <= '0;
                if (row_bad) begin
                  res_status_r <= rhh_pkg::ST_BAD;
                  state_r      <= S_EMIT;
                end else if (norm_r == '0) begin
                  res_status_r <= rhh_pkg::ST_ZERO;
                  state_r      <= S_EMIT;
                end else begin
                  state_r <= S_RD_TAIL;
                end
              end
              default: ;
            endcase
          end
        end
        S_FIN_CHK: begin
          if (j_r == '0) begin
            if (nm1_lt) begin
              state_r <= S_FIN_NORM;
            end else begin
              norm_r    <= run_r;
              fin_pts_r <= CW'(nm1_r) + CW'(1);
              ready_r   <= 1'b1;
              state_r   <= S_IDLE;
            end
          end else begin
            jsq_r     <= (2*AW)'(j_r) * (2*AW)'(j_r);
            use_mem_r <= idx_lt;
            state_r   <= S_FIN_PRD;
          end
        end
        S_FIN_PRD: state_r <= S_FIN_DIV;
        S_FIN_DIV: begin
          if (div_done) begin
            acc_r   <= acc_sum;
            j_r     <= j_r - AW'(1);
            state_r <= S_FIN_CHK;
          end
        end
        S_FIN_NORM: begin
          norm_r    <= prefix_rd_r;
          fin_pts_r <= CW'(nm1_r) + CW'(1);
          ready_r   <= 1'b1;
          state_r   <= S_IDLE;
        end
        S_RD_TAIL: state_r <= S_RD_DIV1;
        S_RD_DIV1: if (div_done) state_r <= S_RD_MUL;
        S_RD_MUL: begin
          if (mul_done) begin
            inter_r <= mul_prod;
            state_r <= S_RD_DIV2;
          end
        end
        S_RD_DIV2: begin
          if (div_done) begin
            nucq_r  <= div_q[REG_W-1:0];
            state_r <= S_RD_SUM;
          end
        end
        S_RD_SUM: begin
          res_diag_r   <= diag_sat;
          res_off_r    <= OUT_W'(0) - OUT_W'(kin_r >> 1);
          res_status_r <= rhh_pkg::ST_OK;
          state_r      <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_row_r    <= res_row_r;
            out_diag_r   <= res_diag_r;
            out_off_r    <= res_off_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row_index      = out_row_r;
  assign out_diag_value     = $signed(out_diag_r);
  assign out_off_diag_value = $signed(out_off_r);
  assign out_status         = out_status_r;

endmodule
`default_nettype wire

// ----- sv/rhh_div.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle
module rhh_div #(
  parameter int NW = 60,
  parameter int DW = 43
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   q_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [DW:0]     trial;
  logic [DW:0]     diff;

  assign trial = {rem_r, q_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_r <= diff[DW-1:0];
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= trial[DW-1:0];
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

// ----- sv/rhh_mul.sv -----
`default_nettype none
// serial shift-add multiply, scaled down by 2^16, saturating to the output range
module rhh_mul #(
  parameter int AW = 60
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [AW-1:0]             a,
  input  wire logic [rhh_pkg::REG_W-1:0] b,
  output logic                           done,
  output logic [rhh_pkg::OUT_W-2:0]      prod
);

  localparam int BW   = rhh_pkg::REG_W;
  localparam int CNTW = $clog2(BW + 1);
  localparam int SW   = ((AW > 63) ? AW : 63) + 2;

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [AW-1:0]   a_r;
  logic [BW-1:0]   b_r;
  logic [62:0]     acc_r;
  logic            sat_r;
  logic [SW-1:0]   sum;
  logic            over;

  // once the product reaches 2^63 the scaled result is past the output range
  assign sum  = SW'({acc_r, 1'b0}) + (b_r[BW-1] ? SW'(a_r) : SW'(0));
  assign over = |sum[SW-1:63];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
      sat_r <= 1'b0;
    end else if (busy_r) begin
      b_r <= {b_r[BW-2:0], 1'b0};
      if (!sat_r) begin
        if (over) begin
          sat_r <= 1'b1;
        end else begin
          acc_r <= sum[62:0];
        end
      end
    end
  end

  assign done = done_r;
  assign prod = sat_r ? rhh_pkg::OUT_MAX[rhh_pkg::OUT_W-2:0] : acc_r[62:16];

endmodule
`default_nettype wire

// ----- sv/rhh_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module rhh_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic [1:0]                  in_action,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [rhh_pkg::ROW_W-1:0]   out_row_index,
  input wire logic [rhh_pkg::OUT_W-1:0]   out_diag_value,
  input wire logic [rhh_pkg::OUT_W-1:0]   out_off_diag_value,
  input wire logic [1:0]                  out_status
);

  logic in_acc;
  assign in_acc = in_valid & ~in_stall;

  `RHH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_row_index) && $stable(out_diag_value) && $stable(out_status), "stalled result beat changed")
  `RHH_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && (out_status != rhh_pkg::ST_OK), (out_diag_value == '0) && (out_off_diag_value == '0), "error beat carries nonzero values")
  `RHH_ASSERT_NOW(a_off_sign, clk, rst_n, out_valid && (out_status == rhh_pkg::ST_OK), out_off_diag_value[rhh_pkg::OUT_W-1] || (out_off_diag_value == '0), "off-diagonal is positive")
  `RHH_ASSERT_NEXT(a_load_fast, clk, rst_n, in_acc && (in_action == rhh_pkg::ACT_LOAD), !in_stall, "load did not finish in one cycle")
  `RHH_ASSERT_NEXT(a_read_busy, clk, rst_n, in_acc && (in_action == rhh_pkg::ACT_READ), in_stall, "read accepted without going busy")

endmodule

bind radial_hartree_hamiltonian_diagonal rhh_checker u_rhh_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_action          (in_action),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_row_index      (out_row_index),
  .out_diag_value     (out_diag_value),
  .out_off_diag_value (out_off_diag_value),
  .out_status         (out_status)
);
`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS     = 4096;
  localparam int WDOG_MAX = 1000000;
  localparam int HOLD_LEN = 3000;
  localparam int N_ITEMS  = 1300;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct {
    logic [rhh_pkg::ROW_W-1:0] row;
    logic [rhh_pkg::OUT_W-1:0] diag;
    logic [rhh_pkg::OUT_W-1:0] off;
    logic [1:0]                status;
  } row_entry_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [1:0]                       in_action = rhh_pkg::ACT_LOAD;
  logic signed [15:0]               in_sample = '0;
  logic [rhh_pkg::ROW_W-1:0]        in_row = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [rhh_pkg::ROW_W-1:0]        out_row_index;
  logic signed [rhh_pkg::OUT_W-1:0] out_diag_value;
  logic signed [rhh_pkg::OUT_W-1:0] out_off_diag_value;
  logic [1:0]                       out_status;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [4:0]                       paddr = '0;
  logic [63:0]                      pwdata = '0;
  logic [63:0]                      prdata;
  logic                             pready;

  radial_hartree_hamiltonian_diagonal DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_sample(in_sample), .in_row(in_row),
    .out_valid(out_valid), .out_stall(out_stall), .out_row_index(out_row_index),
    .out_diag_value(out_diag_value), .out_off_diag_value(out_off_diag_value),
    .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // predicted block state
  longint unsigned sq_prefix [NPTS];
  longint unsigned tail_sum [NPTS];
  int              load_cnt;
  longint unsigned run_sq;
  bit              sums_done;
  longint unsigned norm_tot;
  int              grid_pts;
  longint unsigned kin_q, nuc_q, inv_q;
  int              pts_cfg;

  row_entry_t expected_rows [$];
  int  errors = 0;
  int  items_sent = 0;
  bit  quiet = 0;
  bit  hold_req = 0;
  int  idle_cycles = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint unsigned prefix_upto(longint unsigned k);
    if (k < load_cnt) return sq_prefix[k];
    return run_sq;
  endfunction

  function automatic void grid_load(logic signed [15:0] s);
    longint unsigned mag;
    if (sums_done) begin
      load_cnt = 0;
      run_sq = 0;
      sums_done = 0;
    end
    if (load_cnt >= NPTS) return;
    mag = (s < 0) ? longint'(-int'(s)) : longint'(s);
    run_sq += mag * mag;
    sq_prefix[load_cnt] = run_sq;
    load_cnt++;
  endfunction

  function automatic void grid_finish();
    longint unsigned n, acc, j, p;
    n = (pts_cfg > NPTS) ? NPTS : pts_cfg;
    acc = 0;
    for (longint unsigned m = n; m > 1; m--) begin
      j = m - 1;
      p = prefix_upto(j - 1);
      acc += (p << 16) / (j * j);
      tail_sum[j] = acc;
    end
    if (n > 0) begin
      tail_sum[0] = acc;
      norm_tot = prefix_upto(n - 1);
    end else begin
      norm_tot = 0;
    end
    grid_pts = int'(n);
    sums_done = 1;
  endfunction

  function automatic row_entry_t hamiltonian_row(logic [rhh_pkg::ROW_W-1:0] row);
    row_entry_t e;
    longint unsigned ratio, inter;
    logic [127:0] prod;
    longint d;
    e.row = row;
    e.diag = '0;
    e.off = '0;
    if (!sums_done || row >= grid_pts) begin
      e.status = rhh_pkg::ST_BAD;
    end else if (norm_tot == 0) begin
      e.status = rhh_pkg::ST_ZERO;
    end else begin
      ratio = tail_sum[row] / norm_tot;
      prod = 128'(inv_q) * 128'(ratio);
      if (prod[127:64] != 0) inter = rhh_pkg::OUT_MAX;
      else inter = prod[79:16];
      if (inter > rhh_pkg::OUT_MAX) inter = rhh_pkg::OUT_MAX;
      d = longint'(kin_q) - longint'(nuc_q / (row + 1)) + longint'(inter);
      if (d > longint'(rhh_pkg::OUT_MAX)) d = longint'(rhh_pkg::OUT_MAX);
      if (d < -longint'(rhh_pkg::OUT_MAX) - 1) d = -longint'(rhh_pkg::OUT_MAX) - 1;
      e.diag = d[rhh_pkg::OUT_W-1:0];
      e.off = 48'(64'd0 - (kin_q >> 1));
      e.status = rhh_pkg::ST_OK;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    row_entry_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected beat, row", out_row_index, 0);
      end else begin
        e = expected_rows.pop_front();
        if (out_row_index !== e.row) report_mismatch("row_index", out_row_index, e.row);
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_diag_value !== e.diag) report_mismatch("diag", out_diag_value, e.diag);
        if (out_off_diag_value !== e.off) report_mismatch("off_diag", out_off_diag_value, e.off);
      end
    end
  end

  // receiver back-pressure
  initial begin
    int k;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        k = 0;
        while (k < HOLD_LEN) begin
          @(posedge clk);
          k++;
        end
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (gap_len()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_cmd(logic [1:0] act, logic signed [15:0] smp,
                          logic [rhh_pkg::ROW_W-1:0] row);
    int g;
    g = quiet ? 0 : (($urandom_range(0, 2) == 0) ? gap_len() : 0);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_sample <= smp;
    in_row <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    case (act)
      rhh_pkg::ACT_LOAD:   grid_load(smp);
      rhh_pkg::ACT_FINISH: grid_finish();
      rhh_pkg::ACT_READ:   expected_rows.push_back(hamiltonian_row(row));
      default:             ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  // a trailing read cannot finish before earlier work, so its beat marks idle
  task automatic settle();
    send_cmd(rhh_pkg::ACT_READ, '0, '0);
    drain();
    repeat (200) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, longint unsigned val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rhh_pkg::REG_KIN: kin_q = val & 40'hFF_FFFF_FFFF;
      rhh_pkg::REG_NUC: nuc_q = val & 40'hFF_FFFF_FFFF;
      rhh_pkg::REG_INV: inv_q = val & 40'hFF_FFFF_FFFF;
      default:          pts_cfg = int'(val & 64'h1FFF);
    endcase
  endtask

  task automatic set_regs(longint unsigned k, longint unsigned n, longint unsigned v, int p);
    reg_write(rhh_pkg::REG_KIN, k);
    reg_write(rhh_pkg::REG_NUC, n);
    reg_write(rhh_pkg::REG_INV, v);
    reg_write(rhh_pkg::REG_AP, longint'(p));
  endtask

  task automatic read_rows(int lo, int hi);
    for (int r = lo; r <= hi; r++) send_cmd(rhh_pkg::ACT_READ, '0, rhh_pkg::ROW_W'(r));
  endtask

  task automatic test_unfinished();
    read_rows(0, 1);
    send_cmd(rhh_pkg::ACT_READ, '0, 12'hFFF);
    settle();
  endtask

  task automatic test_directed();
    set_regs(rhh_pkg::KIN_RST, rhh_pkg::NUC_RST, rhh_pkg::INV_RST, 4);
    send_cmd(rhh_pkg::ACT_LOAD, -16'sd32768, '0);
    send_cmd(rhh_pkg::ACT_LOAD, 16'sd32767, '0);
    send_cmd(rhh_pkg::ACT_LOAD, 16'sd0, '0);
    send_cmd(rhh_pkg::ACT_LOAD, -16'sd1, '0);
    send_cmd(rhh_pkg::ACT_FINISH, '0, '0);
    read_rows(0, 4);
    send_cmd(ACT_NONE, 16'sh5A5A, 12'hA5A);
    send_cmd(rhh_pkg::ACT_READ, '0, 12'hFFF);
    // load after finish restarts; two samples on a four-point grid
    send_cmd(rhh_pkg::ACT_LOAD, 16'sd1234, '0);
    send_cmd(rhh_pkg::ACT_LOAD, -16'sd20000, '0);
    send_cmd(rhh_pkg::ACT_FINISH, '0, '0);
    read_rows(0, 3);
    settle();
    // saturating interaction term, then strongly negative diagonal
    set_regs(40'hFF_FFFF_FFFF, 0, 40'hFF_FFFF_FFFF, 3);
    send_cmd(rhh_pkg::ACT_LOAD, 16'sd1, '0);
    send_cmd(rhh_pkg::ACT_LOAD, 16'sd1, '0);
    send_cmd(rhh_pkg::ACT_LOAD, 16'sd1, '0);
    send_cmd(rhh_pkg::ACT_FINISH, '0, '0);
    read_rows(0, 2);
    settle();
    set_regs(0, 40'hFF_FFFF_FFFF, 0, 2);
    send_cmd(rhh_pkg::ACT_FINISH, '0, '0);
    read_rows(0, 1);
    // zero norm
    send_cmd(rhh_pkg::ACT_LOAD, 16'sd0, '0);
    send_cmd(rhh_pkg::ACT_FINISH, '0, '0);
    read_rows(0, 2);
    settle();
    // empty grid
    set_regs(rhh_pkg::KIN_RST, rhh_pkg::NUC_RST, rhh_pkg::INV_RST, 0);
    send_cmd(rhh_pkg::ACT_FINISH, '0, '0);
    send_cmd(rhh_pkg::ACT_READ, '0, '0);
    settle();
  endtask

  task automatic test_random();
    int phase, stop_at, k, reads, n, mode;
    longint unsigned kv, nv, iv;
    logic signed [15:0] s;
    phase = 0;
    stop_at = N_ITEMS;
    while (items_sent < stop_at) begin
      settle();
      mode = $urandom_range(0, 5);
      kv = (mode == 0) ? 40'hFF_FFFF_FFFF : {$urandom_range(0, 255), $urandom()};
      nv = (mode == 1) ? 40'hFF_FFFF_FFFF : {$urandom_range(0, 255), $urandom()};
      iv = (mode == 2) ? 40'hFF_FFFF_FFFF : (mode == 3) ? 0 :
           {$urandom_range(0, 255), $urandom()};
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 48);
      set_regs(kv, nv, iv, n);
      quiet = (phase % 7 == 6);
      k = $urandom_range(0, n + 3);
      for (int i = 0; i < k; i++) begin
        s = (mode == 4) ? 16'sd0 : 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 3) == 0) s = s >>> 10;
        send_cmd(rhh_pkg::ACT_LOAD, s, '0);
      end
      send_cmd(rhh_pkg::ACT_FINISH, '0, '0);
      if (phase == 2) hold_req = 1;
      reads = $urandom_range(10, 30);
      for (int i = 0; i < reads; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_cmd(($urandom_range(0, 1) != 0) ? ACT_NONE : rhh_pkg::ACT_LOAD,
                   16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)));
        end else begin
          send_cmd(rhh_pkg::ACT_READ, '0, ($urandom_range(0, 6) == 0) ?
                   12'($urandom_range(0, 4095)) : 12'($urandom_range(0, n + 1)));
        end
        if (phase == 4 && i == reads / 2) drain();
      end
      quiet = 0;
      phase++;
    end
  endtask

  initial begin
    kin_q = rhh_pkg::KIN_RST;
    nuc_q = rhh_pkg::NUC_RST;
    inv_q = rhh_pkg::INV_RST;
    pts_cfg = int'(rhh_pkg::AP_RST);
    load_cnt = 0;
    run_sq = 0;
    sums_done = 0;
    norm_tot = 0;
    grid_pts = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unfinished();
    test_directed();
    test_random();
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/rhh_pkg.sv
sv/rhh_div.sv
sv/rhh_mul.sv
sv/radial_hartree_hamiltonian_diagonal.sv
sv/rhh_checker.sv
dv/tb_top.sv
